@@ sv/vpl_pkg.sv @@
// vpl_pkg: shared types, constants and microprogram for the velocity pi loop
`default_nettype none
package vpl_pkg;

	// field and datapath widths
	localparam int CNT_FIELD_W = 16;
	localparam int DRIVE_W     = 16;
	localparam int ERR_W       = 26;
	localparam int FILT_W      = 26;
	localparam int INTEG_W     = 27;
	localparam int MA_W        = 27;
	localparam int MB_W        = 17;
	localparam int PROD_W      = MA_W + MB_W;
	localparam int ACC_W       = 60;
	localparam int PC_W        = 4;

	// configuration port
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int TARGET_W  = 16;
	localparam int GAIN_W    = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SPEED_TARGET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 2'd2;

	localparam logic [GAIN_W-1:0] PROP_GAIN_RESET  = 32'd671089;
	localparam logic [GAIN_W-1:0] INTEG_GAIN_RESET = 32'd3355;

	// low-pass coefficients in q8: 205/256 of old plus 51/256 of new
	localparam logic signed [MB_W-1:0] COEF_OLD = 17'sd205;
	localparam logic signed [MB_W-1:0] COEF_NEW = 17'sd51;

	typedef enum logic [1:0] {
		MA_ERR,
		MA_FILT,
		MA_INTEG
	} mul_a_t;

	typedef enum logic [2:0] {
		MB_COEF_OLD,
		MB_COEF_NEW,
		MB_KP_LO,
		MB_KP_HI,
		MB_KI_LO,
		MB_KI_HI
	} mul_b_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_UP16,
		SH_DN8
	} shift_t;

	typedef enum logic [1:0] {
		WB_NONE,
		WB_FILT,
		WB_INTEG,
		WB_OUT
	} wb_t;

	typedef enum logic [1:0] {
		J_NEXT,
		J_WAIT_IN,
		J_WAIT_OUT,
		J_IDLE
	} jump_t;

	typedef struct packed {
		mul_a_t  ma;
		mul_b_t  mb;
		acc_op_t acc;
		shift_t  sh;
		wb_t     wb;
		jump_t   jmp;
	} ctl_t;

	typedef struct packed {
		logic start;
		logic out_free;
	} seq_stat_t;

	// microprogram; the multiplier result is registered, so an accumulate
	// step always consumes the product issued by the step before it
	function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
		ctl_t w;
		w = '{ma: MA_ERR, mb: MB_COEF_OLD, acc: ACC_HOLD, sh: SH_NONE, wb: WB_NONE,
			jmp: J_NEXT};
		case (pc)
			4'd0: begin
				w.jmp = J_WAIT_IN;
			end
			4'd1: begin
				w.ma = MA_FILT;
				w.mb = MB_COEF_OLD;
			end
			4'd2: begin
				w.ma  = MA_ERR;
				w.mb  = MB_COEF_NEW;
				w.acc = ACC_LOAD;
				w.sh  = SH_DN8;
			end
			4'd3: begin
				w.acc = ACC_ADD;
			end
			4'd4: begin
				w.wb = WB_FILT;
			end
			4'd5: begin
				w.wb = WB_INTEG;
				w.ma = MA_FILT;
				w.mb = MB_KP_LO;
			end
			4'd6: begin
				w.ma  = MA_FILT;
				w.mb  = MB_KP_HI;
				w.acc = ACC_LOAD;
			end
			4'd7: begin
				w.ma  = MA_INTEG;
				w.mb  = MB_KI_LO;
				w.acc = ACC_ADD;
				w.sh  = SH_UP16;
			end
			4'd8: begin
				w.ma  = MA_INTEG;
				w.mb  = MB_KI_HI;
				w.acc = ACC_ADD;
			end
			4'd9: begin
				w.acc = ACC_ADD;
				w.sh  = SH_UP16;
			end
			4'd10: begin
				w.wb  = WB_OUT;
				w.jmp = J_WAIT_OUT;
			end
			default: begin
				w.jmp = J_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

@@ sv/vpl_intf.sv @@
// vpl_intf: valid/ready channel interfaces for tick inputs and drive results
`default_nettype none
interface vpl_in_if;
	import vpl_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [CNT_FIELD_W-1:0] left_count;
	logic signed [CNT_FIELD_W-1:0] right_count;
	logic                          stop_request;
	logic                          hold_request;

	modport source(output valid, output left_count, output right_count,
		output stop_request, output hold_request, input ready);
	modport sink(input valid, input left_count, input right_count,
		input stop_request, input hold_request, output ready);
endinterface

interface vpl_out_if;
	import vpl_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] drive;
	logic                      integral_clamped;

	modport source(output valid, output drive, output integral_clamped, input ready);
	modport sink(input valid, input drive, input integral_clamped, output ready);
endinterface
`default_nettype wire

@@ sv/vpl_seq.sv @@
// vpl_seq: step counter, control store and jump logic
`default_nettype none
module vpl_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire vpl_pkg::seq_stat_t  stat,
	output vpl_pkg::ctl_t            ctl
);
	import vpl_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;

	assign ctl = ucode(pc_q);

	always_comb begin
		case (ctl.jmp)
			J_NEXT:     pc_d = pc_q + PC_W'(1);
			J_WAIT_IN:  pc_d = stat.start ? pc_q + PC_W'(1) : pc_q;
			J_WAIT_OUT: pc_d = stat.out_free ? '0 : pc_q;
			J_IDLE:     pc_d = '0;
			default:    pc_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule
`default_nettype wire

@@ sv/vpl_dp.sv @@
// vpl_dp: shared multiplier, accumulator, loop state, config registers, output register
`default_nettype none
module vpl_dp #(
	parameter int INTEGRAL_LIMIT = 240000,
	parameter int COUNT_BITS     = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire vpl_pkg::ctl_t                  ctl,
	output vpl_pkg::seq_stat_t                  stat,
	input  wire logic                           cfg_we,
	input  wire logic [vpl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [vpl_pkg::CFG_W-1:0]      cfg_data,
	vpl_in_if.sink                              in_ch,
	vpl_out_if.source                           out_ch
);
	import vpl_pkg::*;

	localparam int EXT_W = (COUNT_BITS > CNT_FIELD_W) ? COUNT_BITS : CNT_FIELD_W;
	localparam logic signed [ACC_W-1:0] FILT_MAX = ACC_W'((64'sd1 <<< (FILT_W-1)) - 1);
	localparam logic signed [ACC_W-1:0] FILT_MIN = -ACC_W'(64'sd1 <<< (FILT_W-1));
	localparam logic signed [INTEG_W:0] LIM_POS  = (INTEG_W+1)'(INTEGRAL_LIMIT * 256);
	localparam logic signed [INTEG_W:0] LIM_NEG  = -LIM_POS;
	localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'(64'hFFFF_FFFF);
	localparam logic signed [ACC_W-33:0] DRV_MAX = (ACC_W-32)'(32767);
	localparam logic signed [ACC_W-33:0] DRV_MIN = -(ACC_W-32)'(32768);

	// config registers
	logic signed [TARGET_W-1:0] target_q;
	logic [GAIN_W-1:0]          kp_q;
	logic [GAIN_W-1:0]          ki_q;

	// loop state and working registers
	logic signed [FILT_W-1:0]  filt_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W-1:0]   err_q;
	logic                      clear_q;
	logic                      clamp_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;

	// output register
	logic                      out_valid_q;
	logic signed [DRIVE_W-1:0] drive_q;
	logic                      oclamp_q;

	logic                      in_take;
	logic                      out_free;
	logic [EXT_W-1:0]          left_z;
	logic [EXT_W-1:0]          right_z;
	logic signed [ERR_W-1:0]   left_c;
	logic signed [ERR_W-1:0]   right_c;
	logic signed [ERR_W-1:0]   err_d;
	logic signed [MA_W-1:0]    mul_a;
	logic signed [MB_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]  prod_d;
	logic signed [ACC_W-1:0]   acc_in;
	logic signed [FILT_W-1:0]  filt_d;
	logic signed [INTEG_W:0]   integ_sum;
	logic signed [INTEG_W-1:0] integ_d;
	logic                      clamp_d;
	logic signed [ACC_W-1:0]   acc_rnd;
	logic signed [ACC_W-33:0]  acc_hi;
	logic signed [DRIVE_W-1:0] drive_d;

	assign in_ch.ready   = (ctl.jmp == J_WAIT_IN);
	assign in_take       = in_ch.valid && in_ch.ready;
	assign out_free      = !out_valid_q || out_ch.ready;
	assign stat.start    = in_ch.valid;
	assign stat.out_free = out_free;

	assign out_ch.valid            = out_valid_q;
	assign out_ch.drive            = drive_q;
	assign out_ch.integral_clamped = oclamp_q;

	// counts are two's complement in the low COUNT_BITS of the field
	assign left_z  = EXT_W'($unsigned(in_ch.left_count));
	assign right_z = EXT_W'($unsigned(in_ch.right_count));
	assign left_c  = ERR_W'($signed(left_z[COUNT_BITS-1:0]));
	assign right_c = ERR_W'($signed(right_z[COUNT_BITS-1:0]));
	assign err_d   = left_c + right_c - ERR_W'(target_q);

	// operand selection for the shared multiplier
	always_comb begin
		case (ctl.ma)
			MA_ERR:   mul_a = MA_W'(err_q);
			MA_FILT:  mul_a = MA_W'(filt_q);
			MA_INTEG: mul_a = MA_W'(integ_q);
			default:  mul_a = '0;
		endcase
	end

	always_comb begin
		case (ctl.mb)
			MB_COEF_OLD: mul_b = COEF_OLD;
			MB_COEF_NEW: mul_b = COEF_NEW;
			MB_KP_LO:    mul_b = $signed({1'b0, kp_q[15:0]});
			MB_KP_HI:    mul_b = $signed({1'b0, kp_q[31:16]});
			MB_KI_LO:    mul_b = $signed({1'b0, ki_q[15:0]});
			MB_KI_HI:    mul_b = $signed({1'b0, ki_q[31:16]});
			default:     mul_b = '0;
		endcase
	end

	assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

	always_comb begin
		case (ctl.sh)
			SH_NONE: acc_in = ACC_W'(prod_q);
			SH_UP16: acc_in = ACC_W'(prod_q) <<< 16;
			SH_DN8:  acc_in = ACC_W'(prod_q >>> 8);
			default: acc_in = ACC_W'(prod_q);
		endcase
	end

	// filter saturation to the state width
	always_comb begin
		if (acc_q > FILT_MAX) begin
			filt_d = FILT_W'(FILT_MAX);
		end else if (acc_q < FILT_MIN) begin
			filt_d = FILT_W'(FILT_MIN);
		end else begin
			filt_d = FILT_W'(acc_q);
		end
	end

	// integral with clamp; landing on the limit is not a clamp
	assign integ_sum = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(filt_q);
	always_comb begin
		clamp_d = 1'b0;
		integ_d = INTEG_W'(integ_sum);
		if (integ_sum > LIM_POS) begin
			integ_d = INTEG_W'(LIM_POS);
			clamp_d = 1'b1;
		end else if (integ_sum < LIM_NEG) begin
			integ_d = INTEG_W'(LIM_NEG);
			clamp_d = 1'b1;
		end
	end

	// q32 to integer, truncated toward zero, then saturated
	assign acc_rnd = acc_q + (acc_q[ACC_W-1] ? TRUNC_BIAS : '0);
	assign acc_hi  = (ACC_W-32)'(acc_rnd >>> 32);
	always_comb begin
		if (acc_hi > DRV_MAX) begin
			drive_d = DRIVE_W'(DRV_MAX);
		end else if (acc_hi < DRV_MIN) begin
			drive_d = DRIVE_W'(DRV_MIN);
		end else begin
			drive_d = DRIVE_W'(acc_hi);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			kp_q     <= PROP_GAIN_RESET;
			ki_q     <= INTEG_GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPEED_TARGET: target_q <= TARGET_W'(cfg_data);
				REG_PROP_GAIN:    kp_q     <= GAIN_W'(cfg_data);
				REG_INTEG_GAIN:   ki_q     <= GAIN_W'(cfg_data);
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q      <= '0;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (ctl.wb)
				WB_FILT:  filt_q <= filt_d;
				WB_INTEG: integ_q <= integ_d;
				WB_OUT: begin
					if (out_free && clear_q) begin
						integ_q <= '0;
					end
				end
				default:  ;
			endcase
			if (ctl.wb == WB_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (in_take) begin
			err_q   <= err_d;
			clear_q <= in_ch.stop_request || in_ch.hold_request;
		end
		case (ctl.acc)
			ACC_LOAD: acc_q <= acc_in;
			ACC_ADD:  acc_q <= acc_q + acc_in;
			default:  ;
		endcase
		if (ctl.wb == WB_INTEG) begin
			clamp_q <= clamp_d;
		end
		if (ctl.wb == WB_OUT && out_free) begin
			drive_q  <= drive_d;
			oclamp_q <= clamp_q;
		end
	end

endmodule
`default_nettype wire

@@ sv/velocity_pi_with_lowpass_core.sv @@
// velocity_pi_with_lowpass_core: top level of the velocity pi loop with error low-pass
`default_nettype none
// One tick in, one drive value out. The encoder counts are summed, the speed
// target taken off, and the error runs through a q8 low-pass (205/256 old plus
// 51/256 new, floor rounding) into a q8 integral clamped at the integral limit.
// The drive is filtered*kp plus integral*ki with unsigned q8.24 gains, cut
// toward zero and saturated to 16 bits; stop or hold clears the integral once
// the drive is formed. The microprogram has ten working steps over one shared
// 27x17 multiplier, each 32-bit gain used as two 16-bit halves. The result
// sits in an output register, so the next tick is taken while a result still
// waits; the last step only stalls when that register is still full. Config
// writes take effect in the cycle after cfg_we.
module velocity_pi_with_lowpass_core #(
	parameter int INTEGRAL_LIMIT = 240000,
	parameter int COUNT_BITS     = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	vpl_in_if.sink                              in_ch,
	vpl_out_if.source                           out_ch,
	input  wire logic                           cfg_we,
	input  wire logic [vpl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [vpl_pkg::CFG_W-1:0]      cfg_data
);
	import vpl_pkg::*;

	// control word of the current step and status back to the sequencer
	ctl_t      ctl;
	seq_stat_t stat;

	// step counter and control store
	vpl_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	// datapath: operand muxes, multiplier, accumulator, loop state, output register
	vpl_dp #(
		.INTEGRAL_LIMIT (INTEGRAL_LIMIT),
		.COUNT_BITS     (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

endmodule
`default_nettype wire

@@ sv/vpl_chk.sv @@
// vpl_chk: port-level checks on the velocity pi loop, bound to the top level
`default_nettype none
module vpl_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] out_drive
);

	// a pending result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_drive))
		else $error("result changed or dropped before transfer");

	// an input transfer starts the program, so the sink is busy next
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after input transfer");

	// the program is still running well into the tick
	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##8 !in_ready)
		else $error("ready came back before the program finished");

	// a new result only appears at the end of a running program
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while idle");

endmodule

bind velocity_pi_with_lowpass_core vpl_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_drive (out_ch.drive)
);
`default_nettype wire
